>>> hdl/drs_pkg.sv
package drs_pkg;

	localparam int AMOUNT_WIDTH_DEF = 64;
	localparam int OUT_WIDTH        = 64;
	localparam int DPI_WIDTH        = 16;
	localparam logic [DPI_WIDTH-1:0] BASE_DPI = 16'd96;

	typedef enum logic {
		OP_TO_PHYSICAL = 1'b0,
		OP_TO_LOGICAL  = 1'b1
	} op_t;

endpackage

>>> hdl/drs_front.sv
module drs_front #(
	parameter int AMOUNT_WIDTH = drs_pkg::AMOUNT_WIDTH_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	output logic                                        in_ready,
	input  logic                                        operation,
	input  logic [drs_pkg::OUT_WIDTH-1:0]               amount,
	input  logic [drs_pkg::DPI_WIDTH-1:0]               dpi,
	output logic                                        fr_valid,
	input  logic                                        fr_ready,
	output logic                                        fr_neg,
	output logic [AMOUNT_WIDTH+drs_pkg::DPI_WIDTH-1:0] fr_prod,
	output logic [drs_pkg::DPI_WIDTH-1:0]               fr_den
);
	import drs_pkg::*;

	localparam int PW = AMOUNT_WIDTH + DPI_WIDTH;

	logic [AMOUNT_WIDTH-1:0] v;
	logic                    neg;
	logic [AMOUNT_WIDTH-1:0] mag;
	logic [DPI_WIDTH-1:0]    d, num, den;
	logic                    v_s1, neg_s1;
	logic [PW-1:0]           prod_s1;
	logic [DPI_WIDTH-1:0]    den_s1;

	always_comb begin
		v   = amount[AMOUNT_WIDTH-1:0];
		neg = v[AMOUNT_WIDTH-1];
		mag = neg ? (~v + 1'b1) : v;
		d   = (dpi == '0) ? BASE_DPI : dpi;
		if (op_t'(operation) == OP_TO_LOGICAL) begin
			num = BASE_DPI;
			den = d;
		end else begin
			num = d;
			den = BASE_DPI;
		end
	end

	assign in_ready = !v_s1 || fr_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			neg_s1  <= neg;
			prod_s1 <= PW'(mag) * PW'(num);
			den_s1  <= den;
		end
	end

	assign fr_valid = v_s1;
	assign fr_neg   = neg_s1;
	assign fr_prod  = prod_s1;
	assign fr_den   = den_s1;

endmodule

>>> hdl/drs_fifo.sv
module drs_fifo #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  logic [DW-1:0] wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output logic [DW-1:0] rd_data
);
	logic [DW-1:0] mem [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	logic          push, pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= wr_data;
		end
	end

endmodule

>>> hdl/drs_back.sv
module drs_back #(
	parameter int AMOUNT_WIDTH = drs_pkg::AMOUNT_WIDTH_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        bk_valid,
	output logic                                        bk_ready,
	input  logic                                        bk_neg,
	input  logic [AMOUNT_WIDTH+drs_pkg::DPI_WIDTH-1:0] bk_prod,
	input  logic [drs_pkg::DPI_WIDTH-1:0]               bk_den,
	output logic                                        out_valid,
	input  logic                                        out_ready,
	output logic [drs_pkg::OUT_WIDTH-1:0]               scaled,
	output logic                                        saturated
);
	import drs_pkg::*;

	localparam int W  = AMOUNT_WIDTH;
	localparam int QW = W + DPI_WIDTH + 1;

	logic                 en;
	logic                 v_s   [QW+1];
	logic                 neg_s [QW+1];
	logic [DPI_WIDTH-1:0] den_s [QW+1];
	logic [DPI_WIDTH-1:0] rem_s [QW+1];
	logic [QW-1:0]        pr_s  [QW+1];

	logic                 out_v_q, sat_q;
	logic [OUT_WIDTH-1:0] scaled_q;
	logic [QW-1:0]        qf, lim;
	logic                 sat;
	logic [W-1:0]         res;

	assign en       = !out_v_q || out_ready;
	assign bk_ready = en;

	// dividend biased by half the divisor gives round half away from zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= bk_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[0] <= bk_neg;
			den_s[0] <= bk_den;
			rem_s[0] <= '0;
			pr_s[0]  <= QW'(bk_prod) + QW'(bk_den >> 1);
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_div
		logic [DPI_WIDTH:0] trial;
		logic               ge;

		always_comb begin
			trial = {rem_s[i], pr_s[i][QW-1]};
			ge    = (trial >= {1'b0, den_s[i]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[i+1] <= neg_s[i];
				den_s[i+1] <= den_s[i];
				rem_s[i+1] <= ge ? DPI_WIDTH'(trial - {1'b0, den_s[i]})
				                 : trial[DPI_WIDTH-1:0];
				pr_s[i+1]  <= {pr_s[i][QW-2:0], ge};
			end
		end
	end

	always_comb begin
		qf  = pr_s[QW];
		lim = QW'({neg_s[QW], {(W-1){~neg_s[QW]}}});
		sat = (qf > lim);
		if (sat) begin
			res = {neg_s[QW], {(W-1){~neg_s[QW]}}};
		end else if (neg_s[QW]) begin
			res = ~qf[W-1:0] + 1'b1;
		end else begin
			res = qf[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			scaled_q <= OUT_WIDTH'($signed(res));
			sat_q    <= sat;
		end
	end

	assign out_valid = out_v_q;
	assign scaled    = scaled_q;
	assign saturated = sat_q;

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && sat_q |-> (scaled_q[W-1:0] == {1'b1, {(W-1){1'b0}}}
			|| scaled_q[W-1:0] == {1'b0, {(W-1){1'b1}}}))
		else $error("saturated result not at a limit");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[QW] |-> (rem_s[QW] < den_s[QW]))
		else $error("division remainder out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_ready |=> out_v_q && $stable(scaled_q))
		else $error("stalled result lost");

endmodule

>>> hdl/dpi_rounded_scale_top.sv
// Scales a signed coordinate by dpi/96 (operation 0) or 96/dpi (operation 1), zero DPI read as
// 96, rounding half away from zero and saturating to the signed AMOUNT_WIDTH range with the
// saturated flag set; scaled is sign-extended to 64 bits. One transaction is accepted per cycle
// while out_ready holds. The path is a multiply stage, a two-entry queue, a rounding-bias
// register, one stage per quotient bit of the long divider and an output register.
module dpi_rounded_scale_top #(
	parameter int AMOUNT_WIDTH = drs_pkg::AMOUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [drs_pkg::OUT_WIDTH-1:0] amount,
	input  logic [drs_pkg::DPI_WIDTH-1:0] dpi,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [drs_pkg::OUT_WIDTH-1:0] scaled,
	output logic                          saturated
);
	import drs_pkg::*;

	localparam int PW = AMOUNT_WIDTH + DPI_WIDTH;
	localparam int DW = 1 + PW + DPI_WIDTH;

	logic                 fr_valid, fr_ready, fr_neg;
	logic [PW-1:0]        fr_prod;
	logic [DPI_WIDTH-1:0] fr_den;
	logic                 bk_valid, bk_ready;
	logic [DW-1:0]        bk_data;

	drs_front #(.AMOUNT_WIDTH(AMOUNT_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .amount(amount), .dpi(dpi),
		.fr_valid(fr_valid), .fr_ready(fr_ready),
		.fr_neg(fr_neg), .fr_prod(fr_prod), .fr_den(fr_den)
	);

	drs_fifo #(.DW(DW)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fr_valid), .wr_ready(fr_ready),
		.wr_data({fr_neg, fr_prod, fr_den}),
		.rd_valid(bk_valid), .rd_ready(bk_ready), .rd_data(bk_data)
	);

	drs_back #(.AMOUNT_WIDTH(AMOUNT_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.bk_valid(bk_valid), .bk_ready(bk_ready),
		.bk_neg(bk_data[DW-1]),
		.bk_prod(bk_data[DW-2:DPI_WIDTH]),
		.bk_den(bk_data[DPI_WIDTH-1:0]),
		.out_valid(out_valid), .out_ready(out_ready),
		.scaled(scaled), .saturated(saturated)
	);

endmodule
